// ----- sv/tfsp_pkg.sv -----
// ============================================================================
// tfsp_pkg
// Shared types, widths, reset values and codes of the target-follow steering
// planner.
// ============================================================================
package tfsp_pkg;

    // Field widths
    localparam int unsigned ANGLE_W   = 16;
    localparam int unsigned BAND_W    = 14;
    localparam int unsigned WORD_W    = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned DT_W      = 10;
    localparam int unsigned STEER_W   = 16;
    localparam int unsigned MODE_W    = 2;

    // Stream payload widths, padded to whole bytes
    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 24;

    // Configuration port
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Shared multiplier operand and product widths
    localparam int unsigned MUL_W  = 17;
    localparam int unsigned PROD_W = 2 * MUL_W;

    // Defaults of the top-level parameters
    localparam int unsigned OUT_DEADBAND_DEF = 328;
    localparam int unsigned DT_BITS_DEF      = 10;

    // Full-scale steer, Q1.14
    localparam logic [STEER_W-1:0] STEER_ONE = 16'd16384;

    // Register reset values
    localparam logic [BAND_W-1:0] FRONT_FOV_RST    = 14'd3217;
    localparam logic [BAND_W-1:0] ANGLE_DB_RST     = 14'd123;
    localparam logic [BAND_W-1:0] MAX_BEARING_RST  = 14'd12868;
    localparam logic [WORD_W-1:0] STEER_GAIN_RST   = 16'd9102;
    localparam logic [WORD_W-1:0] DECAY_RST        = 16'd65323;
    localparam logic [WORD_W-1:0] HOLD_TIME_RST    = 16'd400;
    localparam logic [WORD_W-1:0] STALE_TIME_RST   = 16'd300;
    localparam logic [WORD_W-1:0] RATE_LIMIT_RST   = 16'd49;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRONT_FOV      = 3'd0,
        CFG_ANGLE_DEADBAND = 3'd1,
        CFG_MAX_BEARING    = 3'd2,
        CFG_STEER_GAIN     = 3'd3,
        CFG_DECAY_PER_MS   = 3'd4,
        CFG_HOLD_TIME      = 3'd5,
        CFG_STALE_TIME     = 3'd6,
        CFG_RATE_LIMIT     = 3'd7
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CENTER = 2'd0,
        MODE_TRACK  = 2'd1,
        MODE_HOLD   = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MODE,
        ST_GAIN,
        ST_DEC_R,
        ST_DEC_B,
        ST_DEC_BW,
        ST_HOLD_MUL,
        ST_HOLD_FIN,
        ST_RATE_FIN
    } state_t;

    // Mode decision handed from the mode logic to the sequencer
    typedef struct packed {
        mode_t mode;
        logic  seen;
    } mode_dec_t;

endpackage

// ----- sv/tfsp_mul.sv -----
// ============================================================================
// tfsp_mul
// Shared unsigned multiplier with a registered product.
// ============================================================================
module tfsp_mul (
    input  logic                        clk,
    input  logic [tfsp_pkg::MUL_W-1:0]  a,
    input  logic [tfsp_pkg::MUL_W-1:0]  b,
    output logic [tfsp_pkg::PROD_W-1:0] p
);
    import tfsp_pkg::*;

    logic [PROD_W-1:0] p_reg;

    // The product is taken in the cycle after the operands are presented.
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ----- sv/tfsp_mode.sv -----
// ============================================================================
// tfsp_mode
// Staleness check and mode transition of one control tick.
// ============================================================================
module tfsp_mode (
    input  logic                        tgt_present,
    input  logic [tfsp_pkg::TIME_W-1:0] sample_stamp,
    input  logic [tfsp_pkg::TIME_W-1:0] now_time,
    input  tfsp_pkg::mode_t             mode_cur,
    input  logic [tfsp_pkg::TIME_W-1:0] last_seen,
    input  logic [tfsp_pkg::WORD_W-1:0] hold_time,
    input  logic [tfsp_pkg::WORD_W-1:0] stale_time,
    output tfsp_pkg::mode_dec_t         dec
);
    import tfsp_pkg::*;

    logic [TIME_W-1:0] age;
    logic [TIME_W-1:0] since;
    logic              stale;
    mode_t             mode_in;
    mode_t             mode_out;

    // An age with the top bit set is a stamp from the future, which is not stale.
    assign age   = now_time - sample_stamp;
    assign since = now_time - last_seen;
    assign stale = (sample_stamp == '0) ||
                   ((age > TIME_W'(stale_time)) && !age[TIME_W-1]);

    assign mode_in = stale ? MODE_HOLD : mode_cur;

    always_comb
    begin
        unique case (mode_in)
            MODE_CENTER: mode_out = tgt_present ? MODE_TRACK : MODE_CENTER;
            MODE_TRACK:  mode_out = tgt_present ? MODE_TRACK : MODE_HOLD;
            default:
            begin
                if (tgt_present)
                    mode_out = MODE_TRACK;
                else if (since > TIME_W'(hold_time))
                    mode_out = MODE_CENTER;
                else
                    mode_out = MODE_HOLD;
            end
        endcase
    end

    assign dec.mode = mode_out;
    assign dec.seen = tgt_present && !stale;

endmodule

// ----- sv/target_follow_steering_planner_core.sv -----
// ============================================================================
// target_follow_steering_planner_core
// Target-follow steering planner: one steering command per control tick.
// ============================================================================
// Usage:
//   Each item on the s_ stream is one control tick. s_tuser carries the
//   target-present flag; s_tdata carries bearing, sample stamp, current time
//   and elapsed milliseconds. For every accepted item exactly one item leaves
//   on the m_ stream with the steering command and the resulting mode.
//   The block works on one tick at a time and holds s_tready low meanwhile.
//   All multiplications run through one shared 17x17 multiplier under a
//   small sequencer. In center mode and for a target outside the field of
//   view or inside the deadband it goes from the mode state straight to the
//   rate-limit state; a bearing scaled by the gain passes the gain state
//   first; in hold mode the decay is raised to the power of the low DT_BITS
//   bits of dt_ms, one bit at a time up to the highest set bit, each bit
//   taking a multiply and a squaring, before the last steer is scaled.
//   s_tready rises together with m_tvalid. The finished command sits in an
//   output register, so a stalled receiver does not block the next tick;
//   only the write of the next result waits. Configuration registers are
//   written through cfg_wr_en, cfg_addr and cfg_wdata; the user must do so
//   only while the block is idle, which the block does not enforce. Reset
//   returns all configuration registers to their defaults, the mode to
//   center, the last-seen time and the steer to zero.
// ============================================================================
module target_follow_steering_planner_core #(
    parameter int unsigned OUT_DEADBAND = tfsp_pkg::OUT_DEADBAND_DEF,
    parameter int unsigned DT_BITS      = tfsp_pkg::DT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Input ticks
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, lowest bit up: target_angle[15:0], sample_stamp[47:16],
    // now_time[79:48], dt_ms[89:80], zero pad[95:90]
    input  logic [tfsp_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: has_target
    input  logic                            s_tuser,
    // Result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, lowest bit up: steer[15:0], mode_now[17:16], zero pad[23:18]
    output logic [tfsp_pkg::M_TDATA_W-1:0]  m_tdata,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic [tfsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tfsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import tfsp_pkg::*;

    // Only the low bits of dt_ms that the decay power covers take part.
    localparam int unsigned DT_USE = (DT_BITS < DT_W) ? DT_BITS : DT_W;
    localparam int unsigned IDX_W  = $clog2(DT_USE);
    localparam int unsigned RND_W  = PROD_W + 1;
    localparam int unsigned EXT_W  = 28;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [BAND_W-1:0] front_fov_reg;
    logic [BAND_W-1:0] angle_db_reg;
    logic [BAND_W-1:0] max_bearing_reg;
    logic [WORD_W-1:0] steer_gain_reg;
    logic [WORD_W-1:0] decay_reg;
    logic [WORD_W-1:0] hold_time_reg;
    logic [WORD_W-1:0] stale_time_reg;
    logic [WORD_W-1:0] rate_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_fov_reg   <= FRONT_FOV_RST;
            angle_db_reg    <= ANGLE_DB_RST;
            max_bearing_reg <= MAX_BEARING_RST;
            steer_gain_reg  <= STEER_GAIN_RST;
            decay_reg       <= DECAY_RST;
            hold_time_reg   <= HOLD_TIME_RST;
            stale_time_reg  <= STALE_TIME_RST;
            rate_limit_reg  <= RATE_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_FRONT_FOV:      front_fov_reg   <= cfg_wdata[BAND_W-1:0];
                CFG_ANGLE_DEADBAND: angle_db_reg    <= cfg_wdata[BAND_W-1:0];
                CFG_MAX_BEARING:    max_bearing_reg <= cfg_wdata[BAND_W-1:0];
                CFG_STEER_GAIN:     steer_gain_reg  <= cfg_wdata;
                CFG_DECAY_PER_MS:   decay_reg       <= cfg_wdata;
                CFG_HOLD_TIME:      hold_time_reg   <= cfg_wdata;
                CFG_STALE_TIME:     stale_time_reg  <= cfg_wdata;
                CFG_RATE_LIMIT:     rate_limit_reg  <= cfg_wdata;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    state_t                    state_reg, state_next;

    // Latched tick
    logic                      has_reg, has_next;
    logic signed [ANGLE_W-1:0] angle_reg, angle_next;
    logic [TIME_W-1:0]         stamp_reg, stamp_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic [DT_USE-1:0]         dt_reg, dt_next;

    // Persistent planner state
    mode_t                     mode_reg, mode_next;
    logic [TIME_W-1:0]         last_seen_reg, last_seen_next;
    logic signed [STEER_W-1:0] prev_reg, prev_next;

    // Working registers
    logic signed [STEER_W-1:0] cmd_reg, cmd_next;
    logic                      neg_reg, neg_next;
    logic [MUL_W-1:0]          r_reg, r_next;
    logic [WORD_W-1:0]         base_reg, base_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic signed [STEER_W-1:0] out_steer_reg, out_steer_next;
    mode_t                     out_mode_reg, out_mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_CENTER;
            last_seen_reg <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            last_seen_reg <= last_seen_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        has_reg       <= has_next;
        angle_reg     <= angle_next;
        stamp_reg     <= stamp_next;
        now_reg       <= now_next;
        dt_reg        <= dt_next;
        cmd_reg       <= cmd_next;
        neg_reg       <= neg_next;
        r_reg         <= r_next;
        base_reg      <= base_next;
        idx_reg       <= idx_next;
        out_steer_reg <= out_steer_next;
        out_mode_reg  <= out_mode_next;
    end

    // ------------------------------------------------------------------
    // Mode decision
    // ------------------------------------------------------------------
    mode_dec_t dec;

    tfsp_mode u_mode (
        .tgt_present  (has_reg),
        .sample_stamp (stamp_reg),
        .now_time     (now_reg),
        .mode_cur     (mode_reg),
        .last_seen    (last_seen_reg),
        .hold_time    (hold_time_reg),
        .stale_time   (stale_time_reg),
        .dec          (dec)
    );

    // ------------------------------------------------------------------
    // Shared multiplier
    // ------------------------------------------------------------------
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    tfsp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Product with the rounding offsets of Q0.16 and of the gain scaling.
    logic [RND_W-1:0] rnd16;
    logic [RND_W-1:0] rnd10;

    assign rnd16 = RND_W'(mul_p) + RND_W'(32768);
    assign rnd10 = RND_W'(mul_p) + RND_W'(512);

    // ------------------------------------------------------------------
    // Bearing clamp and field-of-view tests
    // ------------------------------------------------------------------
    logic signed [ANGLE_W-1:0] bear_lim;
    logic signed [ANGLE_W-1:0] bear_clamp;
    logic [ANGLE_W-1:0]        bear_abs;
    logic [BAND_W-1:0]         bear_mag;
    logic                      out_of_fov;
    logic                      in_band;

    assign bear_lim = $signed(ANGLE_W'(max_bearing_reg));

    always_comb
    begin
        if (angle_reg > bear_lim)
            bear_clamp = bear_lim;
        else if (angle_reg < -bear_lim)
            bear_clamp = -bear_lim;
        else
            bear_clamp = angle_reg;
    end

    // After the clamp the magnitude never exceeds the 14-bit limit.
    assign bear_abs   = bear_clamp[ANGLE_W-1] ? ANGLE_W'(-bear_clamp) : ANGLE_W'(bear_clamp);
    assign bear_mag   = bear_abs[BAND_W-1:0];
    assign out_of_fov = bear_mag > front_fov_reg;
    assign in_band    = bear_mag <= angle_db_reg;

    // ------------------------------------------------------------------
    // Decay loop helpers and previous-steer magnitude
    // ------------------------------------------------------------------
    logic              more_bits;
    logic [14:0]       prev_abs;
    logic [DT_USE-1:0] dt_rest;

    // Further set bits of dt above the current one still need a squared base.
    assign dt_rest   = (dt_reg >> idx_reg) >> 1;
    assign more_bits = |dt_rest;
    assign prev_abs  = prev_reg[STEER_W-1] ? 15'(-prev_reg) : 15'(prev_reg);

    // ------------------------------------------------------------------
    // Gain scaling and decay results
    // ------------------------------------------------------------------
    logic [RND_W-11:0]         gain_raw;
    logic [14:0]               gain_sat;
    logic [14:0]               hold_mag;

    assign gain_raw = rnd10[RND_W-1:10];
    assign gain_sat = (gain_raw > (RND_W-10)'(STEER_ONE)) ? 15'(STEER_ONE) : gain_raw[14:0];
    assign hold_mag = rnd16[30:16];

    // ------------------------------------------------------------------
    // Rate limit and output deadband
    // ------------------------------------------------------------------
    logic signed [EXT_W-1:0]   prev_ext;
    logic signed [EXT_W-1:0]   ds;
    logic signed [EXT_W-1:0]   maxds;
    logic signed [EXT_W-1:0]   limited;
    logic signed [STEER_W-1:0] shaped;
    logic [STEER_W:0]          shaped_abs;
    logic signed [STEER_W-1:0] final_steer;

    assign prev_ext = EXT_W'(prev_reg);
    assign ds       = EXT_W'(cmd_reg) - prev_ext;
    assign maxds    = $signed(EXT_W'(mul_p[25:0]));

    always_comb
    begin
        priority if (dt_reg == '0)
            limited = prev_ext;
        else if (ds > maxds)
            limited = prev_ext + maxds;
        else if (ds < -maxds)
            limited = prev_ext - maxds;
        else
            limited = EXT_W'(cmd_reg);
    end

    assign shaped      = limited[STEER_W-1:0];
    assign shaped_abs  = shaped[STEER_W-1] ? (STEER_W+1)'(-(STEER_W+1)'(shaped))
                                           : (STEER_W+1)'(shaped);
    assign final_steer = (shaped_abs < (STEER_W+1)'(OUT_DEADBAND)) ? '0 : shaped;

    logic out_free;

    assign out_free = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_MODE;
            end
            ST_MODE:
            begin
                priority if (dec.mode == MODE_HOLD)
                    state_next = ST_DEC_R;
                else if (dec.mode == MODE_TRACK && !out_of_fov && !in_band)
                    state_next = ST_GAIN;
                else
                    state_next = ST_RATE_FIN;
            end
            ST_GAIN:     state_next = ST_RATE_FIN;
            ST_DEC_R:    state_next = ST_DEC_B;
            ST_DEC_B:    state_next = more_bits ? ST_DEC_BW : ST_HOLD_MUL;
            ST_DEC_BW:   state_next = ST_DEC_R;
            ST_HOLD_MUL: state_next = ST_HOLD_FIN;
            ST_HOLD_FIN: state_next = ST_RATE_FIN;
            ST_RATE_FIN:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        has_next       = has_reg;
        angle_next     = angle_reg;
        stamp_next     = stamp_reg;
        now_next       = now_reg;
        dt_next        = dt_reg;
        mode_next      = mode_reg;
        last_seen_next = last_seen_reg;
        prev_next      = prev_reg;
        cmd_next       = cmd_reg;
        neg_next       = neg_reg;
        r_next         = r_reg;
        base_next      = base_reg;
        idx_next       = idx_reg;
        out_steer_next = out_steer_reg;
        out_mode_next  = out_mode_reg;
        out_valid_next = out_valid_reg && !m_tready;
        // By default the multiplier forms the rate-limit step, which the
        // final state reads; it stays stable while that state waits.
        mul_a          = MUL_W'(rate_limit_reg);
        mul_b          = MUL_W'(dt_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    has_next   = s_tuser;
                    angle_next = $signed(s_tdata[15:0]);
                    stamp_next = s_tdata[47:16];
                    now_next   = s_tdata[79:48];
                    dt_next    = s_tdata[80 +: DT_USE];
                end
            end
            ST_MODE:
            begin
                mode_next = dec.mode;
                if (dec.seen)
                    last_seen_next = now_reg;
                unique case (dec.mode)
                    MODE_TRACK:
                    begin
                        priority if (out_of_fov)
                        begin
                            mode_next = MODE_HOLD;
                            cmd_next  = prev_reg;
                        end
                        else if (in_band)
                            cmd_next = '0;
                        else
                        begin
                            mul_a    = MUL_W'(bear_mag);
                            mul_b    = MUL_W'(steer_gain_reg);
                            neg_next = bear_clamp[ANGLE_W-1];
                        end
                    end
                    MODE_HOLD:
                    begin
                        r_next    = MUL_W'(65536);
                        base_next = decay_reg;
                        idx_next  = '0;
                    end
                    default: cmd_next = '0;
                endcase
            end
            ST_GAIN:
            begin
                cmd_next = neg_reg ? -$signed(STEER_W'(gain_sat))
                                   : $signed(STEER_W'(gain_sat));
            end
            ST_DEC_R:
            begin
                mul_a = r_reg;
                mul_b = MUL_W'(base_reg);
            end
            ST_DEC_B:
            begin
                if (dt_reg[idx_reg])
                    r_next = rnd16[32:16];
                mul_a = MUL_W'(base_reg);
                mul_b = MUL_W'(base_reg);
            end
            ST_DEC_BW:
            begin
                base_next = rnd16[31:16];
                idx_next  = idx_reg + 1'b1;
            end
            ST_HOLD_MUL:
            begin
                mul_a = MUL_W'(prev_abs);
                mul_b = r_reg;
            end
            ST_HOLD_FIN:
            begin
                cmd_next = prev_reg[STEER_W-1] ? -$signed(STEER_W'(hold_mag))
                                               : $signed(STEER_W'(hold_mag));
            end
            ST_RATE_FIN:
            begin
                if (out_free)
                begin
                    prev_next      = final_steer;
                    out_steer_next = final_steer;
                    out_mode_next  = mode_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - STEER_W - MODE_W)'(0), out_mode_reg, out_steer_reg};

endmodule

// ----- sv/tfsp_checker.sv -----
// ============================================================================
// tfsp_checker
// Port-level assertions of the steering planner, bound to the top level.
// ============================================================================
module tfsp_checker #(
    parameter int unsigned OUT_DEADBAND = tfsp_pkg::OUT_DEADBAND_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tfsp_pkg::M_TDATA_W-1:0] m_tdata
);
    import tfsp_pkg::*;

    logic signed [STEER_W-1:0] steer;
    logic [STEER_W:0]          steer_abs;

    assign steer     = $signed(m_tdata[STEER_W-1:0]);
    assign steer_abs = steer[STEER_W-1] ? (STEER_W+1)'(-(STEER_W+1)'(steer))
                                        : (STEER_W+1)'(steer);

    // A tick is worked on alone, so input is refused right after acceptance.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a tick is in progress");

    // The command never leaves plus or minus one full.
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (steer <= $signed(STEER_ONE)) && (steer >= -$signed(STEER_ONE)))
        else $error("steer outside full scale");

    // Small commands are forced to zero by the output deadband.
    a_out_deadband: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (steer == '0) || (steer_abs >= (STEER_W+1)'(OUT_DEADBAND)))
        else $error("steer inside output deadband");

    // A stalled result stays offered unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind target_follow_steering_planner_core tfsp_checker #(
    .OUT_DEADBAND (OUT_DEADBAND)
) u_tfsp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
